[design/irfd_pkg.sv]
// shared types, constants and the decode step table for the inverter response frame decoder
// no dependencies; imported by inverter_response_frame_decoder_unit
`default_nettype none

package irfd_pkg;

    localparam int FRAME_BYTES  = 46;
    localparam int POS_W        = 6;
    localparam int KIND_W       = 5;
    localparam int VERDICT_W    = 2;
    localparam int VALUE_W      = 32;
    localparam int OUT_DEPTH_DEF = 8;

    // frame positions
    localparam logic [POS_W-1:0] POS_STX      = 6'd0;
    localparam logic [POS_W-1:0] POS_LEN      = 6'd1;
    localparam logic [POS_W-1:0] POS_ID       = 6'd6;
    localparam logic [POS_W-1:0] POS_ACK      = 6'd7;
    localparam logic [POS_W-1:0] POS_SUM_LO   = 6'd5;
    localparam logic [POS_W-1:0] POS_SUM_HI   = 6'd42;
    localparam logic [POS_W-1:0] POS_CHK_HI   = 6'd43;
    localparam logic [POS_W-1:0] POS_CHK_LO   = 6'd44;
    localparam logic [POS_W-1:0] POS_LAST     = 6'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] POS_END      = 6'(FRAME_BYTES);

    localparam logic [7:0] STX_BYTE    = 8'h02;
    localparam logic [7:0] LEN_BYTE    = 8'h2E;
    localparam logic [7:0] ACK_BYTE    = 8'h06;
    localparam logic [7:0] PHASE1_CODE = 8'h11;
    localparam logic [7:0] PHASE3_CODE = 8'h33;

    // floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for any 32-bit x
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_OK      = 2'd0,
        VERDICT_HEADER  = 2'd1,
        VERDICT_ID      = 2'd2,
        VERDICT_CHKSUM  = 2'd3
    } verdict_t;

    typedef enum logic [2:0] {
        OP_BYTE  = 3'd0,   // high byte of the word
        OP_PHASE = 3'd1,   // phase code of the high byte
        OP_HOLD  = 3'd2,   // keep word as upper half, no item
        OP_LO32  = 3'd3,   // held word and this word
        OP_W16   = 3'd4,
        OP_NZ    = 3'd5,
        OP_WACC  = 3'd6,   // power accumulator, no read used
        OP_ERR   = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        MUL_NONE = 2'd0,
        MUL_SET  = 2'd1,
        MUL_ADD  = 2'd2
    } mul_t;

    typedef struct packed {
        logic [POS_W-1:0]  addr;
        op_t               op;
        mul_t              mul;
        logic [KIND_W-1:0] kind;
    } step_t;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_LAST = 5'd20;

    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic [KIND_W-1:0]    kind;
        logic [VERDICT_W-1:0] verdict;
        logic                 last;
    } out_item_t;

    // one word read per step; the multiply pairs each current word with the previous one
    function automatic step_t step_rom(input logic [STEP_W-1:0] idx);
        step_t s;
        s = '{addr: 6'd0, op: OP_WACC, mul: MUL_NONE, kind: 5'd0};
        case (idx)
            5'd0:  s = '{addr: 6'd6,  op: OP_BYTE,  mul: MUL_NONE, kind: 5'd0};
            5'd1:  s = '{addr: 6'd8,  op: OP_PHASE, mul: MUL_NONE, kind: 5'd1};
            5'd2:  s = '{addr: 6'd11, op: OP_HOLD,  mul: MUL_NONE, kind: 5'd2};
            5'd3:  s = '{addr: 6'd13, op: OP_LO32,  mul: MUL_NONE, kind: 5'd2};
            5'd4:  s = '{addr: 6'd15, op: OP_HOLD,  mul: MUL_NONE, kind: 5'd3};
            5'd5:  s = '{addr: 6'd17, op: OP_LO32,  mul: MUL_NONE, kind: 5'd3};
            5'd6:  s = '{addr: 6'd19, op: OP_W16,   mul: MUL_NONE, kind: 5'd4};
            5'd7:  s = '{addr: 6'd21, op: OP_W16,   mul: MUL_SET,  kind: 5'd5};
            5'd8:  s = '{addr: 6'd23, op: OP_W16,   mul: MUL_NONE, kind: 5'd6};
            5'd9:  s = '{addr: 6'd25, op: OP_W16,   mul: MUL_ADD,  kind: 5'd7};
            5'd10: s = '{addr: 6'd0,  op: OP_WACC,  mul: MUL_NONE, kind: 5'd8};
            5'd11: s = '{addr: 6'd27, op: OP_W16,   mul: MUL_NONE, kind: 5'd9};
            5'd12: s = '{addr: 6'd29, op: OP_W16,   mul: MUL_SET,  kind: 5'd10};
            5'd13: s = '{addr: 6'd31, op: OP_W16,   mul: MUL_NONE, kind: 5'd11};
            5'd14: s = '{addr: 6'd33, op: OP_W16,   mul: MUL_NONE, kind: 5'd12};
            5'd15: s = '{addr: 6'd35, op: OP_W16,   mul: MUL_NONE, kind: 5'd13};
            5'd16: s = '{addr: 6'd37, op: OP_W16,   mul: MUL_NONE, kind: 5'd14};
            5'd17: s = '{addr: 6'd0,  op: OP_WACC,  mul: MUL_NONE, kind: 5'd15};
            5'd18: s = '{addr: 6'd9,  op: OP_NZ,    mul: MUL_NONE, kind: 5'd16};
            5'd19: s = '{addr: 6'd39, op: OP_W16,   mul: MUL_NONE, kind: 5'd17};
            5'd20: s = '{addr: 6'd41, op: OP_W16,   mul: MUL_NONE, kind: 5'd18};
            default: s = '{addr: 6'd0, op: OP_WACC, mul: MUL_NONE, kind: 5'd0};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

[design/inverter_response_frame_decoder_unit.sv]
// inverter response frame decoder: byte intake, two-bank frame memory, decode pipeline, result queue
// depends on irfd_pkg
`default_nettype none
// results: after frame byte 45 is accepted, one item per cycle while the result queue has room
//   (19 items over 21 decode steps, one word read from the frame memory per step, or one error item)
// throughput: one byte per cycle; byte 45 of a frame waits while the previous frame's steps
//   are still being issued, since the frame memory has two banks
// reset: byte count, checksum, flags, decoder and queue cleared; frame memory is not cleared

module inverter_response_frame_decoder_unit #(
    parameter int OUT_DEPTH = irfd_pkg::OUT_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,   // inverter_id
    // byte input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] rx_byte
    input  wire logic        s_tuser,       // [0] frame_start
    // result output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,       // [1:0] verdict, [6:2] value_kind, [38:7] value, pad
    output logic             m_tlast        // last
);
    import irfd_pkg::*;

    // bank bit sits above the frame position
    localparam int MEM_DEPTH = 2 << POS_W;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int QPTR_W    = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int QCNT_W    = $clog2(OUT_DEPTH + 1);

    // ---------------- configuration ----------------
    logic [7:0] inverter_id_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inverter_id_reg <= '0;
        end else if (cfg_wr_en) begin
            inverter_id_reg <= cfg_wr_data;
        end
    end

    // ---------------- byte intake ----------------
    logic [POS_W-1:0] count_reg, count_next;
    logic [15:0]      sum_reg, sum_next;
    logic             hdr_bad_reg, hdr_bad_next;
    logic             chk_bad_reg, chk_bad_next;
    logic [7:0]       id_byte_reg;
    logic             wbank_reg;
    logic             s_acc, pos_ok, wr_en, frame_done;
    logic [POS_W-1:0] pos;
    logic [7:0]       rx_byte;
    verdict_t         verdict_now;

    logic             dec_busy_reg;
    logic             dec_bank_reg;
    verdict_t         dec_verdict_reg;
    logic [STEP_W-1:0] step_reg;

    assign rx_byte = s_tdata[7:0];
    // a frame may not complete while the previous one is still being read from the other bank
    assign s_tready = !(dec_busy_reg && count_reg == POS_LAST);
    assign s_acc    = s_tvalid && s_tready;
    assign pos      = s_tuser ? POS_STX : count_reg;
    assign pos_ok   = pos < POS_END;
    assign wr_en    = s_acc && pos_ok;
    assign frame_done = wr_en && pos == POS_LAST;

    always_comb begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        hdr_bad_next = hdr_bad_reg;
        chk_bad_next = chk_bad_reg;
        if (wr_en) begin
            count_next = pos + 6'd1;
            if (pos == POS_STX) begin
                sum_next     = '0;
                hdr_bad_next = rx_byte != STX_BYTE;
                chk_bad_next = 1'b0;
            end
            if (pos >= POS_SUM_LO && pos <= POS_SUM_HI) begin
                sum_next = sum_next + {8'h00, rx_byte};
            end
            if ((pos == POS_LEN && rx_byte != LEN_BYTE) ||
                (pos == POS_ACK && rx_byte != ACK_BYTE)) begin
                hdr_bad_next = 1'b1;
            end
            if ((pos == POS_CHK_HI && rx_byte != sum_reg[15:8]) ||
                (pos == POS_CHK_LO && rx_byte != sum_reg[7:0])) begin
                chk_bad_next = 1'b1;
            end
        end
    end

    always_comb begin
        if (hdr_bad_reg) begin
            verdict_now = VERDICT_HEADER;
        end else if (id_byte_reg != inverter_id_reg) begin
            verdict_now = VERDICT_ID;
        end else if (chk_bad_reg) begin
            verdict_now = VERDICT_CHKSUM;
        end else begin
            verdict_now = VERDICT_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            sum_reg     <= '0;
            hdr_bad_reg <= 1'b0;
            chk_bad_reg <= 1'b0;
            wbank_reg   <= 1'b0;
        end else begin
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            hdr_bad_reg <= hdr_bad_next;
            chk_bad_reg <= chk_bad_next;
            if (frame_done) begin
                wbank_reg <= !wbank_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && pos == POS_ID) begin
            id_byte_reg <= rx_byte;
        end
    end

    // ---------------- frame memory, two banks ----------------
    logic [7:0]        frame_mem [MEM_DEPTH];
    logic [MEM_AW-1:0] wr_addr, rd_addr0, rd_addr1;
    logic [7:0]        rd_q0, rd_q1;
    step_t             step_cur;

    assign step_cur = step_rom(step_reg);
    assign wr_addr  = MEM_AW'({wbank_reg, pos});
    assign rd_addr0 = MEM_AW'({dec_bank_reg, step_cur.addr});
    assign rd_addr1 = MEM_AW'({dec_bank_reg, step_cur.addr + 6'd1});

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            frame_mem[wr_addr] <= rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        rd_q0 <= frame_mem[rd_addr0];
        rd_q1 <= frame_mem[rd_addr1];
    end

    // ---------------- step sequencer ----------------
    logic [QCNT_W-1:0] q_count_reg;
    logic              s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [QCNT_W+1:0] credit_used;
    logic              issue, issue_done;
    op_t               issue_op;

    assign credit_used = (QCNT_W+2)'(q_count_reg) + (QCNT_W+2)'(s1_vld_reg)
                       + (QCNT_W+2)'(s2_vld_reg) + (QCNT_W+2)'(s3_vld_reg);
    assign issue      = dec_busy_reg && credit_used < (QCNT_W+2)'(OUT_DEPTH);
    assign issue_op   = (dec_verdict_reg != VERDICT_OK) ? OP_ERR : step_cur.op;
    assign issue_done = dec_verdict_reg != VERDICT_OK || step_reg == STEP_LAST;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_busy_reg    <= 1'b0;
            dec_bank_reg    <= 1'b0;
            dec_verdict_reg <= VERDICT_OK;
            step_reg        <= '0;
        end else if (frame_done) begin
            dec_busy_reg    <= 1'b1;
            dec_bank_reg    <= wbank_reg;
            dec_verdict_reg <= verdict_now;
            step_reg        <= '0;
        end else if (issue) begin
            step_reg <= step_reg + 5'd1;
            if (issue_done) begin
                dec_busy_reg <= 1'b0;
            end
        end
    end

    // ---------------- decode pipeline ----------------
    op_t               s1_op_reg, s2_op_reg, s3_op_reg;
    mul_t              s1_mul_reg, s2_mul_reg, s3_mul_reg;
    logic [KIND_W-1:0] s1_kind_reg, s2_kind_reg, s3_kind_reg;
    verdict_t          s1_verdict_reg, s2_verdict_reg, s3_verdict_reg;
    logic              s1_last_reg, s2_last_reg, s3_last_reg;
    logic [31:0]       s2_val_reg, s3_val_reg;
    logic [31:0]       s2_prod_reg;
    logic [28:0]       s3_quot_reg;
    logic [15:0]       hold_reg, prev_w_reg;
    logic [31:0]       wacc_reg;
    logic [15:0]       s1_word;
    logic [31:0]       s1_val;
    logic [63:0]       s2_recip_prod;

    assign s1_word = {rd_q0, rd_q1};

    always_comb begin
        case (s1_op_reg)
            OP_BYTE:  s1_val = {24'h0, rd_q0};
            OP_PHASE: begin
                if (rd_q0 == PHASE1_CODE) begin
                    s1_val = 32'd1;
                end else if (rd_q0 == PHASE3_CODE) begin
                    s1_val = 32'd3;
                end else begin
                    s1_val = 32'd0;
                end
            end
            OP_LO32:  s1_val = {hold_reg, s1_word};
            OP_W16:   s1_val = {16'h0, s1_word};
            OP_NZ:    s1_val = {31'h0, s1_word != 16'h0};
            default:  s1_val = 32'd0;
        endcase
    end

    assign s2_recip_prod = {32'h0, s2_prod_reg} * {32'h0, RECIP10};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_op_reg      <= issue_op;
        s1_mul_reg     <= step_cur.mul;
        s1_kind_reg    <= (dec_verdict_reg != VERDICT_OK) ? '0 : step_cur.kind;
        s1_verdict_reg <= dec_verdict_reg;
        s1_last_reg    <= issue_done;

        s2_op_reg      <= s1_op_reg;
        s2_mul_reg     <= s1_mul_reg;
        s2_kind_reg    <= s1_kind_reg;
        s2_verdict_reg <= s1_verdict_reg;
        s2_last_reg    <= s1_last_reg;
        s2_val_reg     <= s1_val;
        // voltage word from the step before times current word of this step
        s2_prod_reg    <= {16'h0, prev_w_reg} * {16'h0, s1_word};

        s3_op_reg      <= s2_op_reg;
        s3_mul_reg     <= s2_mul_reg;
        s3_kind_reg    <= s2_kind_reg;
        s3_verdict_reg <= s2_verdict_reg;
        s3_last_reg    <= s2_last_reg;
        s3_val_reg     <= s2_val_reg;
        s3_quot_reg    <= s2_recip_prod[RECIP10_SHIFT +: 29];

        if (s1_vld_reg) begin
            prev_w_reg <= s1_word;
            if (s1_op_reg == OP_HOLD) begin
                hold_reg <= s1_word;
            end
        end
        if (s3_vld_reg) begin
            case (s3_mul_reg)
                MUL_SET: wacc_reg <= {3'h0, s3_quot_reg};
                MUL_ADD: wacc_reg <= wacc_reg + {3'h0, s3_quot_reg};
                default: wacc_reg <= wacc_reg;
            endcase
        end
    end

    // ---------------- result queue ----------------
    out_item_t         queue_mem [OUT_DEPTH];
    logic [QPTR_W-1:0] q_wr_ptr_reg, q_rd_ptr_reg;
    logic              q_wr, q_rd;
    out_item_t         q_in, q_head;

    assign q_wr = s3_vld_reg && s3_op_reg != OP_HOLD;
    assign q_rd = m_tvalid && m_tready;

    always_comb begin
        q_in.kind    = s3_kind_reg;
        q_in.verdict = s3_verdict_reg;
        q_in.last    = s3_last_reg;
        case (s3_op_reg)
            OP_WACC: q_in.value = wacc_reg;
            OP_ERR:  q_in.value = '0;
            default: q_in.value = s3_val_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (q_wr) begin
            queue_mem[q_wr_ptr_reg] <= q_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_count_reg  <= '0;
        end else begin
            if (q_wr) begin
                q_wr_ptr_reg <= (q_wr_ptr_reg == QPTR_W'(OUT_DEPTH - 1)) ? '0
                                                                        : q_wr_ptr_reg + 1'b1;
            end
            if (q_rd) begin
                q_rd_ptr_reg <= (q_rd_ptr_reg == QPTR_W'(OUT_DEPTH - 1)) ? '0
                                                                        : q_rd_ptr_reg + 1'b1;
            end
            case ({q_wr, q_rd})
                2'b10:   q_count_reg <= q_count_reg + 1'b1;
                2'b01:   q_count_reg <= q_count_reg - 1'b1;
                default: q_count_reg <= q_count_reg;
            endcase
        end
    end

    assign q_head   = queue_mem[q_rd_ptr_reg];
    assign m_tvalid = q_count_reg != '0;
    assign m_tdata  = {1'b0, q_head.value, q_head.kind, q_head.verdict};
    assign m_tlast  = q_head.last;

    // ---------------- checks ----------------
    a_bank_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && dec_busy_reg) |-> (wbank_reg != dec_bank_reg))
        else $error("frame write hits the bank under decode");

    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_wr |-> (q_count_reg < QCNT_W'(OUT_DEPTH) || q_rd))
        else $error("result queue overflow");

    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && issue_done && !frame_done) |=> !dec_busy_reg)
        else $error("decoder still busy after final step");

    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_vld_reg && s3_op_reg == OP_ERR) |-> (s3_verdict_reg != VERDICT_OK && s3_last_reg))
        else $error("error item without a failing verdict");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |-> !dec_busy_reg)
        else $error("frame completed while previous decode active");

endmodule

`default_nettype wire
